@@ src/v3n_pkg.sv @@
// shared constants for the vector normalizer
package v3n_pkg;
	localparam int WORD_W     = 32;
	localparam int SQ_W       = 2 * WORD_W;
	localparam int FRAC_UNIT  = 30;
	localparam int QUO_W      = FRAC_UNIT + 1;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int LANES      = 3;
	localparam int DIV_LAT    = QUO_W + 1;
	localparam int ALIGN_LAT  = SQRT_STEPS + 1;
	localparam int TOTAL_LAT  = 1 + 1 + SQRT_STEPS + DIV_LAT;
endpackage

@@ src/v3n_if.sv @@
// valid/ready channel interfaces for vectors in and normalized results out
interface v3n_in_if;
	import v3n_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] vec_x;
	logic signed [WORD_W-1:0] vec_y;
	logic signed [WORD_W-1:0] vec_z;
	modport source(output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink(input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v3n_out_if;
	import v3n_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] unit_x;
	logic signed [WORD_W-1:0] unit_y;
	logic signed [WORD_W-1:0] unit_z;
	logic        [WORD_W-1:0] vec_length;
	logic                     zero_length;
	modport source(output valid, output unit_x, output unit_y, output unit_z,
		output vec_length, output zero_length, input ready);
	modport sink(input valid, input unit_x, input unit_y, input unit_z,
		input vec_length, input zero_length, output ready);
endinterface

@@ src/v3n_square.sv @@
// per-lane magnitude, sign and exact square of one component
module v3n_square (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [v3n_pkg::WORD_W-1:0]  comp,
	output logic        [v3n_pkg::WORD_W-1:0]  mag_s1,
	output logic                               neg_s1,
	output logic        [v3n_pkg::SQ_W-1:0]    sq_s1
);
	import v3n_pkg::*;

	logic [WORD_W-1:0] mag;

	assign mag = comp[WORD_W-1] ? WORD_W'(-comp) : WORD_W'(comp);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			neg_s1 <= comp[WORD_W-1];
			sq_s1  <= SQ_W'(mag) * SQ_W'(mag);
		end
	end
endmodule

@@ src/v3n_sqrt.sv @@
// pipelined digit-by-digit integer square root, one root bit per stage
module v3n_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [v3n_pkg::SQ_W-1:0]       radicand,
	output logic [v3n_pkg::WORD_W-1:0]     root
);
	import v3n_pkg::*;

	localparam int REM_W = WORD_W + 4;

	logic [REM_W-1:0]  rem_s  [SQRT_STEPS];
	logic [WORD_W-1:0] root_s [SQRT_STEPS];
	logic [SQ_W-1:0]   rad_s  [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in;
		logic [WORD_W-1:0] root_in;
		logic [SQ_W-1:0]   rad_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end
		assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
		assign trial  = {2'b00, root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_in[SQ_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_in[WORD_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_in[WORD_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1];
endmodule

@@ src/v3n_div.sv @@
// per-lane pipelined restoring divider giving signed q2.30 component over length
module v3n_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic        [v3n_pkg::WORD_W-1:0]  mag,
	input  logic                               neg,
	input  logic        [v3n_pkg::WORD_W-1:0]  len,
	output logic signed [v3n_pkg::WORD_W-1:0]  quo
);
	import v3n_pkg::*;

	localparam int R_W = WORD_W + 1;

	logic [WORD_W-1:0] r_s   [QUO_W];
	logic [QUO_W-1:0]  q_s   [QUO_W];
	logic [WORD_W-1:0] len_s [QUO_W];
	logic              neg_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		logic [R_W-1:0]    r_in;
		logic [QUO_W-1:0]  q_in;
		logic [WORD_W-1:0] len_in;
		logic              neg_in;
		logic              ge;
		logic [R_W-1:0]    diff;
		if (j == 0) begin : g_first
			assign r_in   = {1'b0, mag};
			assign q_in   = '0;
			assign len_in = len;
			assign neg_in = neg;
		end else begin : g_next
			assign r_in   = {r_s[j-1], 1'b0};
			assign q_in   = q_s[j-1];
			assign len_in = len_s[j-1];
			assign neg_in = neg_s[j-1];
		end
		assign ge   = (len_in != '0) && (r_in >= {1'b0, len_in});
		assign diff = r_in - {1'b0, len_in};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]   <= ge ? diff[WORD_W-1:0] : r_in[WORD_W-1:0];
				q_s[j]   <= {q_in[QUO_W-2:0], ge};
				len_s[j] <= len_in;
				neg_s[j] <= neg_in;
			end
		end
	end

	logic [WORD_W-1:0] q_ext;
	assign q_ext = WORD_W'(q_s[QUO_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QUO_W-1] ? WORD_W'(-q_ext) : q_ext;
		end
	end
endmodule

@@ src/vector3_normalize.sv @@
// top level: three lanes of square and divide around a shared square root pipeline
// datapath from accepted vector to result: square, sum, 32 root stages, 32 divide stages
// throughput: one vector per cycle unless stalled, set by the fully pipelined root and divide lanes
// a stalled output freezes the whole pipeline; ready is high whenever the last stage is empty or taken
// reset clears only the valid pipeline; payload registers are not reset
module vector3_normalize (
	input  logic  clk,
	input  logic  arst_n,
	v3n_in_if.sink    in_ch,
	v3n_out_if.source out_ch
);
	import v3n_pkg::*;

	logic [TOTAL_LAT-1:0] vld_q;
	logic                 en;

	assign en          = !vld_q[TOTAL_LAT-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = vld_q[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_ch.valid};
		end
	end

	logic signed [WORD_W-1:0] comp [LANES];
	logic [WORD_W-1:0]        mag_s1 [LANES];
	logic                     neg_s1 [LANES];
	logic [SQ_W-1:0]          sq_s1  [LANES];

	assign comp[0] = in_ch.vec_x;
	assign comp[1] = in_ch.vec_y;
	assign comp[2] = in_ch.vec_z;

	for (genvar l = 0; l < LANES; l++) begin : g_sq
		v3n_square u_square (
			.clk    (clk),
			.en     (en),
			.comp   (comp[l]),
			.mag_s1 (mag_s1[l]),
			.neg_s1 (neg_s1[l]),
			.sq_s1  (sq_s1[l])
		);
	end

	logic [SQ_W-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	logic [WORD_W-1:0] root;

	v3n_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s2),
		.root     (root)
	);

	// align magnitudes and signs with the root
	logic [WORD_W-1:0] mag_dl [ALIGN_LAT][LANES];
	logic              neg_dl [ALIGN_LAT][LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				mag_dl[0][l] <= mag_s1[l];
				neg_dl[0][l] <= neg_s1[l];
				for (int d = 1; d < ALIGN_LAT; d++) begin
					mag_dl[d][l] <= mag_dl[d-1][l];
					neg_dl[d][l] <= neg_dl[d-1][l];
				end
			end
		end
	end

	logic signed [WORD_W-1:0] quo [LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_div
		v3n_div u_div (
			.clk (clk),
			.en  (en),
			.mag (mag_dl[ALIGN_LAT-1][l]),
			.neg (neg_dl[ALIGN_LAT-1][l]),
			.len (root),
			.quo (quo[l])
		);
	end

	logic [WORD_W-1:0] len_dl [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			len_dl[0] <= root;
			for (int d = 1; d < DIV_LAT; d++) begin
				len_dl[d] <= len_dl[d-1];
			end
		end
	end

	assign out_ch.unit_x      = quo[0];
	assign out_ch.unit_y      = quo[1];
	assign out_ch.unit_z      = quo[2];
	assign out_ch.vec_length  = len_dl[DIV_LAT-1];
	assign out_ch.zero_length = (len_dl[DIV_LAT-1] == '0);

`ifndef SYNTHESIS
	a_zero_units: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.zero_length |->
		out_ch.unit_x == '0 && out_ch.unit_y == '0 && out_ch.unit_z == '0)
		else $error("zero vector with nonzero unit components");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.vec_length)
		&& $stable(out_ch.unit_x))
		else $error("pipeline moved while output stalled");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
		(out_ch.unit_x <= 32'sh4000_0000 && out_ch.unit_x >= -32'sh4000_0000))
		else $error("unit component out of range");
`endif
endmodule
